[rtl/cps_pkg.sv]
`default_nettype none
package cps_pkg;

  // sense field width on the stream and number of cameras fitted
  localparam int CAM_W       = 5;
  localparam int NUM_CAMERAS = 5;

  localparam logic [CAM_W-1:0] SENSE_MASK =
    (NUM_CAMERAS >= CAM_W) ? {CAM_W{1'b1}} : CAM_W'((1 << NUM_CAMERAS) - 1);
  // with more cameras than sense bits "all on" can never be seen
  localparam logic ALL_ON_OK = (NUM_CAMERAS <= CAM_W);

  localparam int IN_W  = 8;
  localparam int OUT_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // mode codes; the first six are also the displayed state codes
  localparam logic [2:0] M_OFF      = 3'd0;
  localparam logic [2:0] M_SHUTFAIL = 3'd1;
  localparam logic [2:0] M_OPENFAIL = 3'd2;
  localparam logic [2:0] M_SHUTTING = 3'd3;
  localparam logic [2:0] M_POWERING = 3'd4;
  localparam logic [2:0] M_ON       = 3'd5;
  localparam logic [2:0] M_STARTUP  = 3'd6;
  localparam logic [2:0] M_PHOTO    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHOTO_WAIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY       = 2'd3;

  localparam logic [7:0] RST_CHECK_LIMIT = 8'd50;
  localparam logic [5:0] RST_BEEP_TICKS  = 6'd5;
  localparam logic [7:0] RST_PHOTO_WAIT  = 8'd90;
  localparam logic [3:0] RST_RETRY       = 4'd8;

  localparam logic [7:0] UP_POLL_TICKS    = 8'd3;
  localparam logic [7:0] POST_PHOTO_TICKS = 8'd30;

  typedef struct packed {
    logic [CAM_W-1:0] cam_power_bits;
    logic             key_press;
    logic             start_allowed;
  } cps_in_t;

  typedef struct packed {
    logic       report;
    logic [2:0] state_code;
    logic       photo_trigger;
    logic       buzzer;
    logic       power_on;
  } cps_out_t;

  typedef struct packed {
    logic [7:0] check_limit;
    logic [5:0] beep_ticks;
    logic [7:0] photo_wait_ticks;
    logic [3:0] retry_period;
  } cps_cfg_t;

endpackage
`default_nettype wire

[rtl/cps_cfg.sv]
`default_nettype none
module cps_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cps_pkg::CFG_DATA_W-1:0] cfg_data,
  output cps_pkg::cps_cfg_t                   cfg
);
  import cps_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_limit      <= RST_CHECK_LIMIT;
      cfg.beep_ticks       <= RST_BEEP_TICKS;
      cfg.photo_wait_ticks <= RST_PHOTO_WAIT;
      cfg.retry_period     <= RST_RETRY;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHECK_LIMIT: cfg.check_limit      <= cfg_data[7:0];
        REG_BEEP_TICKS:  cfg.beep_ticks       <= cfg_data[5:0];
        REG_PHOTO_WAIT:  cfg.photo_wait_ticks <= cfg_data[7:0];
        REG_RETRY:       cfg.retry_period     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/cps_fsm.sv]
`default_nettype none
module cps_fsm (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         advance,
  input  cps_pkg::cps_in_t  item,
  input  cps_pkg::cps_cfg_t cfg,
  output cps_pkg::cps_out_t result
);
  import cps_pkg::*;

  logic [2:0] mode, mode_next;
  logic [7:0] wait_count, wait_next;
  logic [7:0] check_count, check_next;
  logic [3:0] fail_count, fail_next;
  logic [5:0] beep_count, beep_next;
  logic       power_level, power_next;

  logic [CAM_W-1:0] bits;
  logic             all_off, all_on, key;
  logic             buz, photo, rep, ann;
  logic [2:0]       ann_mode;
  logic [3:0]       fail_inc;
  logic [7:0]       check_inc, wait_inc;

  function automatic logic fail_beep(input logic [3:0] fc);
    return (fc inside {4'd1, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15});
  endfunction

  assign bits      = item.cam_power_bits & SENSE_MASK;
  assign all_off   = (bits == '0);
  assign all_on    = ALL_ON_OK && (bits == SENSE_MASK);
  assign key       = item.key_press;
  assign fail_inc  = fail_count + 4'd1;
  assign check_inc = check_count + 8'd1;
  assign wait_inc  = wait_count + 8'd1;

  always_comb begin
    mode_next  = mode;
    wait_next  = wait_count;
    check_next = check_count;
    fail_next  = fail_count;
    beep_next  = beep_count;
    power_next = power_level;
    buz        = 1'b0;
    photo      = 1'b0;
    rep        = 1'b0;
    ann        = 1'b0;
    ann_mode   = mode;

    if (beep_count != '0) begin
      beep_next = beep_count - 6'd1;
      buz       = 1'b1;
    end else begin
      case (mode)
        M_OFF: begin
          if (key) begin
            power_next = 1'b1;
            ann = 1'b1; ann_mode = M_POWERING;
          end else if (!all_off) begin
            power_next = 1'b0;
            ann = 1'b1; ann_mode = M_SHUTFAIL;
          end
        end
        M_SHUTFAIL: begin
          fail_next = fail_inc;
          buz       = fail_beep(fail_inc);
          if (fail_inc >= cfg.retry_period) begin
            power_next = 1'b0;
            fail_next  = '0;
          end
          if (all_off) begin
            ann = 1'b1; ann_mode = M_OFF;
          end else if (key) begin
            power_next = 1'b1;
            ann = 1'b1; ann_mode = M_POWERING;
          end
        end
        M_OPENFAIL: begin
          fail_next = fail_inc;
          buz       = fail_beep(fail_inc);
          if (fail_inc >= cfg.retry_period) begin
            power_next = 1'b1;
            fail_next  = '0;
          end
          if (all_on) begin
            // fail_count carries the code shown during the photo wait
            mode_next  = M_PHOTO;
            wait_next  = '0;
            check_next = '0;
            fail_next  = {1'b0, M_OPENFAIL};
          end else if (key) begin
            power_next = 1'b0;
            ann = 1'b1; ann_mode = M_SHUTTING;
          end
        end
        M_SHUTTING: begin
          power_next = 1'b0;
          check_next = check_inc;
          if (all_off) begin
            ann = 1'b1; ann_mode = M_OFF;
          end else if (check_inc >= cfg.check_limit) begin
            ann = 1'b1; ann_mode = M_SHUTFAIL;
          end
        end
        M_POWERING: begin
          power_next = 1'b1;
          wait_next  = wait_inc;
          if (wait_inc >= UP_POLL_TICKS) begin
            wait_next  = '0;
            check_next = check_inc;
            if (all_on) begin
              mode_next  = M_PHOTO;
              check_next = '0;
              fail_next  = {1'b0, M_POWERING};
            end else if (check_inc >= cfg.check_limit) begin
              ann = 1'b1; ann_mode = M_OPENFAIL;
            end
          end
        end
        M_PHOTO: begin
          // check_count marks the phase: zero before the pulse, one after
          if (check_count == '0) begin
            if (wait_count >= cfg.photo_wait_ticks) begin
              photo      = 1'b1;
              check_next = 8'd1;
              wait_next  = '0;
            end else begin
              wait_next = wait_inc;
            end
          end else begin
            if (wait_count >= POST_PHOTO_TICKS) begin
              ann = 1'b1; ann_mode = M_ON;
            end else begin
              wait_next = wait_inc;
            end
          end
        end
        M_ON: ;
        default: begin
          if (item.start_allowed) begin
            power_next = 1'b0;
            ann = 1'b1;
            ann_mode = all_off ? M_OFF : M_SHUTFAIL;
          end
        end
      endcase
    end

    if (ann) begin
      mode_next  = ann_mode;
      rep        = 1'b1;
      buz        = 1'b1;
      beep_next  = (cfg.beep_ticks == '0) ? 6'd0 : cfg.beep_ticks - 6'd1;
      wait_next  = '0;
      check_next = '0;
      fail_next  = '0;
    end

    result.power_on      = power_next;
    result.buzzer        = buz;
    result.photo_trigger = photo;
    result.report        = rep;
    if (mode_next == M_STARTUP) begin
      result.state_code = M_OFF;
    end else if (mode_next == M_PHOTO) begin
      result.state_code = fail_next[2:0];
    end else begin
      result.state_code = mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_STARTUP;
      wait_count  <= '0;
      check_count <= '0;
      fail_count  <= '0;
      beep_count  <= '0;
      power_level <= 1'b0;
    end else if (advance) begin
      mode        <= mode_next;
      wait_count  <= wait_next;
      check_count <= check_next;
      fail_count  <= fail_next;
      beep_count  <= beep_next;
      power_level <= power_next;
    end
  end
endmodule
`default_nettype wire

[rtl/camera_power_sequencer.sv]
// a tick request's result reaches the master side via the input register,
// then the result register; it waits while the result register is stalled
// throughput: one tick per cycle unless stalled; state updates in one pass
// reset (rst, synchronous): startup phase, power command off, registers at
// their defaults, both stream sides empty
`default_nettype none
module camera_power_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] start_allowed, [1] key_press, [6:2] cam_power_bits, [7] zero
  input  wire logic [cps_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] power_on, [1] buzzer, [2] photo_trigger, [5:3] state_code,
  // [6] report, [7] zero
  output logic [cps_pkg::OUT_W-1:0]           m_axis_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cps_pkg::*;

  logic      in_valid;
  cps_in_t   in_item;
  logic      advance;
  cps_cfg_t  cfg;
  cps_out_t  result;
  cps_out_t  out_item;

  // the held request moves on whenever the result register is free or draining
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tdata  = {{(OUT_W - $bits(cps_out_t)){1'b0}}, out_item};

  cps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cps_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= cps_in_t'(s_axis_tdata[$bits(cps_in_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end
endmodule
`default_nettype wire

[rtl/cps_checker.sv]
`default_nettype none
module cps_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [cps_pkg::OUT_W-1:0]      m_axis_tdata
);
  import cps_pkg::*;

  logic [2:0] code;
  assign code = m_axis_tdata[5:3];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an announced state change always sounds the buzzer
  a_report_beep: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[1])
    else $error("report without buzzer");

  // the photo pulse only comes during the wait after a confirmed power-up
  a_photo_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |->
      !m_axis_tdata[6] && (code == M_POWERING || code == M_OPENFAIL) && m_axis_tdata[0])
    else $error("photo pulse outside power-up wait");

  // in the on state the power command stays on and no photo pulse comes
  a_on_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && code == M_ON |->
      m_axis_tdata[0] && !m_axis_tdata[2])
    else $error("on state without power");

endmodule

bind camera_power_sequencer cps_checker u_cps_checker (.*);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
  import cps_pkg::*;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  typed;
    cps_in_t               tick;
    cps_out_t              res;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [0] start_allowed, [1] key_press, [6:2] cam_power_bits, [7] zero
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] power_on, [1] buzzer, [2] photo_trigger, [5:3] state_code, [6] report, [7] zero
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  camera_power_sequencer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer state as predicted
  logic [2:0] seq_mode;
  logic [7:0] seq_wait;
  logic [7:0] seq_checks;
  logic [3:0] seq_fails;
  logic [5:0] seq_beep;
  logic       seq_power;
  logic       seq_report;
  logic [7:0] lim_checks;
  logic [5:0] beep_len;
  logic [7:0] photo_wait;
  logic [3:0] retry_at;

  cps_out_t expected_results [$];
  logic steady = 1'b0;
  int failures = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int photo_pulses = 0;

  function automatic void enter_state(logic [2:0] m);
    seq_mode   = m;
    seq_report = 1'b1;
    seq_beep   = (beep_len != 0) ? beep_len - 6'd1 : 6'd0;
    seq_wait   = '0;
    seq_checks = '0;
    seq_fails  = '0;
  endfunction

  // returns the buzzer level for this failure tick
  function automatic logic count_failure();
    logic buzz;
    seq_fails = seq_fails + 4'd1;
    buzz = (seq_fails == 4'd1) || (seq_fails % 3 == 0);
    if (seq_fails >= retry_at) begin
      seq_power = (seq_mode == M_OPENFAIL);
      seq_fails = '0;
    end
    return buzz;
  endfunction

  function automatic cps_out_t advance_sequencer(cps_in_t t);
    logic [CAM_W-1:0] bits;
    logic all_off, all_on, buzz, flash;
    cps_out_t r;
    bits = t.cam_power_bits & SENSE_MASK;
    all_off = (bits == '0);
    all_on = ALL_ON_OK && (bits == SENSE_MASK);
    buzz = 1'b0;
    flash = 1'b0;
    seq_report = 1'b0;
    if (seq_beep != 0) begin
      seq_beep = seq_beep - 6'd1;
      buzz = 1'b1;
    end else begin
      case (seq_mode)
        M_OFF: begin
          if (t.key_press) begin
            seq_power = 1'b1;
            enter_state(M_POWERING);
          end else if (!all_off) begin
            seq_power = 1'b0;
            enter_state(M_SHUTFAIL);
          end
        end
        M_SHUTFAIL: begin
          buzz = count_failure();
          if (all_off) begin
            enter_state(M_OFF);
          end else if (t.key_press) begin
            seq_power = 1'b1;
            enter_state(M_POWERING);
          end
        end
        M_OPENFAIL: begin
          buzz = count_failure();
          // photo wait keeps showing the code it came from
          if (all_on) begin
            seq_mode = M_PHOTO;
            seq_wait = '0;
            seq_checks = '0;
            seq_fails = 4'(M_OPENFAIL);
          end else if (t.key_press) begin
            seq_power = 1'b0;
            enter_state(M_SHUTTING);
          end
        end
        M_SHUTTING: begin
          seq_power = 1'b0;
          seq_checks = seq_checks + 8'd1;
          if (all_off) begin
            enter_state(M_OFF);
          end else if (seq_checks >= lim_checks) begin
            enter_state(M_SHUTFAIL);
          end
        end
        M_POWERING: begin
          seq_power = 1'b1;
          seq_wait = seq_wait + 8'd1;
          if (seq_wait >= UP_POLL_TICKS) begin
            seq_wait = '0;
            seq_checks = seq_checks + 8'd1;
            if (all_on) begin
              seq_mode = M_PHOTO;
              seq_checks = '0;
              seq_fails = 4'(M_POWERING);
            end else if (seq_checks >= lim_checks) begin
              enter_state(M_OPENFAIL);
            end
          end
        end
        M_PHOTO: begin
          // check count 0: before the pulse, 1: after it
          if (seq_checks == 0) begin
            if (seq_wait >= photo_wait) begin
              flash = 1'b1;
              seq_checks = 8'd1;
              seq_wait = '0;
            end else begin
              seq_wait = seq_wait + 8'd1;
            end
          end else if (seq_wait >= POST_PHOTO_TICKS) begin
            enter_state(M_ON);
          end else begin
            seq_wait = seq_wait + 8'd1;
          end
        end
        M_ON: begin
        end
        default: begin
          if (t.start_allowed) begin
            seq_power = 1'b0;
            enter_state(all_off ? M_OFF : M_SHUTFAIL);
          end
        end
      endcase
    end
    if (flash) photo_pulses++;
    r.power_on = seq_power;
    r.buzzer = buzz | seq_report;
    r.photo_trigger = flash;
    r.state_code = (seq_mode == M_STARTUP) ? M_OFF :
                   (seq_mode == M_PHOTO) ? seq_fails[2:0] : seq_mode;
    r.report = seq_report;
    return r;
  endfunction

  // in the closing phase cameras follow the power command loosely; elsewhere
  // "all on" is kept out of power-up so the terminal on state is not reached
  function automatic cps_in_t pick_tick(logic closing);
    cps_in_t t;
    t.start_allowed = 1'($urandom);
    t.key_press = ($urandom_range(99) < (closing ? 20 : 15));
    if (closing) begin
      if ($urandom_range(99) < 85) t.cam_power_bits = seq_power ? 5'h1F : 5'h00;
      else t.cam_power_bits = 5'($urandom);
    end else if (seq_mode == M_POWERING || seq_mode == M_OPENFAIL) begin
      if ($urandom_range(1) == 0) t.cam_power_bits = ~(5'd1 << $urandom_range(4));
      else t.cam_power_bits = 5'($urandom_range(30));
    end else begin
      case ($urandom_range(2))
        0: t.cam_power_bits = 5'h00;
        1: t.cam_power_bits = 5'h1F;
        default: t.cam_power_bits = 5'($urandom);
      endcase
    end
    return t;
  endfunction

  function automatic plan_row_t tick_row(logic st, logic key, logic [CAM_W-1:0] cam);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.tick.start_allowed = st;
    r.tick.key_press = key;
    r.tick.cam_power_bits = cam;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic st, logic key, logic [CAM_W-1:0] cam,
                                          logic pwr, logic buzz, logic [2:0] code,
                                          logic rep);
    plan_row_t r;
    r = tick_row(st, key, cam);
    r.typed = 1'b1;
    r.res.power_on = pwr;
    r.res.buzzer = buzz;
    r.res.photo_trigger = 1'b0;
    r.res.state_code = code;
    r.res.report = rep;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [2:0] want, logic [2:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  task automatic send_tick(input cps_in_t t, input logic use_typed, input cps_out_t typed_res);
    cps_out_t predicted;
    if (cfg_valid) cfg_valid <= 1'b0;
    while (!steady && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, t};
    do @(posedge clk); while (!s_axis_tready);
    predicted = advance_sequencer(t);
    expected_results.push_back(use_typed ? typed_res : predicted);
    ticks_sent++;
  endtask

  // valid stays up across back-to-back writes; send_tick lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CHECK_LIMIT: lim_checks = val;
      REG_BEEP_TICKS:  beep_len = val[5:0];
      REG_PHOTO_WAIT:  photo_wait = val;
      default:         retry_at = val[3:0];
    endcase
    reg_writes++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    cps_out_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
        failures++;
      end else begin
        want = expected_results.pop_front();
        got = cps_out_t'(m_axis_tdata[6:0]);
        compare_field("power_on", 3'(want.power_on), 3'(got.power_on));
        compare_field("buzzer", 3'(want.buzzer), 3'(got.buzzer));
        compare_field("photo_trigger", 3'(want.photo_trigger), 3'(got.photo_trigger));
        compare_field("state_code", want.state_code, got.state_code);
        compare_field("report", 3'(want.report), 3'(got.report));
        compare_field("pad", 3'd0, 3'(m_axis_tdata[7]));
        results_checked++;
      end
    end
  end

  always @(posedge clk) m_axis_tready <= steady || ($urandom_range(99) >= 21);

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    plan_row_t plan [26];
    int ph;
    int on_ticks;
    int closing_ticks;
    seq_mode = M_STARTUP;
    seq_wait = '0;
    seq_checks = '0;
    seq_fails = '0;
    seq_beep = '0;
    seq_power = 1'b0;
    seq_report = 1'b0;
    lim_checks = RST_CHECK_LIMIT;
    beep_len = RST_BEEP_TICKS;
    photo_wait = RST_PHOTO_WAIT;
    retry_at = RST_RETRY;

    plan = '{
      // ticks before start are ignored
      typed_row(1'b0, 1'b1, 5'h1F, 1'b0, 1'b0, M_OFF, 1'b0),
      typed_row(1'b0, 1'b0, 5'h00, 1'b0, 1'b0, M_OFF, 1'b0),
      // start with cameras still on
      typed_row(1'b1, 1'b0, 5'h15, 1'b0, 1'b1, M_SHUTFAIL, 1'b1),
      // default beep holds four more ticks, keys dropped
      typed_row(1'b0, 1'b1, 5'h01, 1'b0, 1'b1, M_SHUTFAIL, 1'b0),
      typed_row(1'b0, 1'b1, 5'h01, 1'b0, 1'b1, M_SHUTFAIL, 1'b0),
      typed_row(1'b0, 1'b1, 5'h01, 1'b0, 1'b1, M_SHUTFAIL, 1'b0),
      typed_row(1'b0, 1'b1, 5'h01, 1'b0, 1'b1, M_SHUTFAIL, 1'b0),
      tick_row(1'b1, 1'b0, 5'h02),
      typed_row(1'b0, 1'b1, 5'h08, 1'b1, 1'b1, M_POWERING, 1'b1),
      reg_row(REG_CHECK_LIMIT, 8'h00),
      reg_row(REG_BEEP_TICKS, 8'h00),
      reg_row(REG_RETRY, 8'h00),
      reg_row(REG_PHOTO_WAIT, 8'hFF),
      // beep already running is not cut short
      typed_row(1'b0, 1'b0, 5'h00, 1'b1, 1'b1, M_POWERING, 1'b0),
      typed_row(1'b0, 1'b0, 5'h00, 1'b1, 1'b1, M_POWERING, 1'b0),
      typed_row(1'b0, 1'b0, 5'h00, 1'b1, 1'b1, M_POWERING, 1'b0),
      typed_row(1'b0, 1'b0, 5'h00, 1'b1, 1'b1, M_POWERING, 1'b0),
      // zero check limit: the first failed poll fails
      tick_row(1'b0, 1'b1, 5'h1E),
      tick_row(1'b0, 1'b0, 5'h1E),
      typed_row(1'b0, 1'b0, 5'h1E, 1'b1, 1'b1, M_OPENFAIL, 1'b1),
      tick_row(1'b0, 1'b0, 5'h00),
      typed_row(1'b0, 1'b1, 5'h00, 1'b0, 1'b1, M_SHUTTING, 1'b1),
      typed_row(1'b0, 1'b0, 5'h10, 1'b0, 1'b1, M_SHUTFAIL, 1'b1),
      typed_row(1'b0, 1'b0, 5'h00, 1'b0, 1'b1, M_OFF, 1'b1),
      typed_row(1'b0, 1'b0, 5'h00, 1'b0, 1'b0, M_OFF, 1'b0),
      typed_row(1'b1, 1'b1, 5'h04, 1'b1, 1'b1, M_POWERING, 1'b1)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!cfg_valid) wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].tick, plan[i].typed, plan[i].res);
      end
    end

    // every phase starts from a drained pipe with a fresh register set
    for (ph = 0; ph < 13; ph++) begin
      wait_idle();
      steady = (ph == 3);
      if (ph == 1) begin
        write_reg(REG_CHECK_LIMIT, 8'hFF);
        write_reg(REG_BEEP_TICKS, 8'hFF);
        write_reg(REG_PHOTO_WAIT, 8'hFF);
        write_reg(REG_RETRY, 8'hFF);
      end else if (ph == 2) begin
        write_reg(REG_CHECK_LIMIT, 8'h00);
        write_reg(REG_BEEP_TICKS, 8'h00);
        write_reg(REG_PHOTO_WAIT, 8'h00);
        write_reg(REG_RETRY, 8'h00);
      end else begin
        write_reg(REG_CHECK_LIMIT, 8'((ph % 4 == 0) ? $urandom_range(40) : $urandom_range(6)));
        write_reg(REG_BEEP_TICKS, {2'($urandom), 6'($urandom_range(4))});
        write_reg(REG_PHOTO_WAIT, 8'($urandom));
        write_reg(REG_RETRY, {4'($urandom), 4'($urandom_range(15))});
      end
      repeat (50) send_tick(pick_tick(1'b0), 1'b0, '0);
    end

    // closing phase: let power-up succeed, pulse the trigger and settle in on
    wait_idle();
    steady = 1'b0;
    write_reg(REG_CHECK_LIMIT, 8'd4);
    write_reg(REG_BEEP_TICKS, 8'd2);
    write_reg(REG_PHOTO_WAIT, 8'($urandom_range(12)));
    write_reg(REG_RETRY, 8'($urandom_range(1, 15)));
    on_ticks = 0;
    closing_ticks = 0;
    while (on_ticks < 20 && closing_ticks < 400) begin
      send_tick(pick_tick(1'b1), 1'b0, '0);
      closing_ticks++;
      if (seq_mode == M_ON) on_ticks++;
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("%0d ticks sent, %0d results checked, %0d register writes",
             ticks_sent, results_checked, reg_writes);
    $display("%0d photo pulses predicted, final state code %0d", photo_pulses, seq_mode);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[camera_power_sequencer.f]
rtl/cps_pkg.sv
rtl/cps_cfg.sv
rtl/cps_fsm.sv
rtl/camera_power_sequencer.sv
rtl/cps_checker.sv
bench/tb.sv
